// ===== hw/rtl/tksd_pkg.sv =====
// Package with the parse phase type and key code constants of the terminal key decoder.
package tksd_pkg;

    // Parse phase of an escape sequence in progress.
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ESC     = 3'd1,
        PH_CSI     = 3'd2,
        PH_CSI3    = 3'd3,
        PH_CSI1    = 3'd4,
        PH_CSI1S   = 3'd5,
        PH_CSI1S5  = 3'd6
    } phase_t;

    typedef logic [7:0] byte_t;
    typedef logic [7:0] key_t;
    typedef logic [6:0] ascii_t;

    // Dense key codes.
    localparam key_t KC_NONE     = 8'd0;
    localparam key_t KC_ENTER    = 8'd1;
    localparam key_t KC_PRINT0   = 8'd2;
    localparam key_t KC_CTRL_A   = 8'd97;
    localparam key_t KC_BKSP     = 8'd123;
    localparam key_t KC_ESC      = 8'd124;
    localparam key_t KC_DEL      = 8'd125;
    localparam key_t KC_ARROW0   = 8'd126;
    localparam key_t KC_CARROW0  = 8'd130;
    localparam key_t KC_LAST     = 8'd133;

    // Received byte values with a meaning of their own.
    localparam byte_t CH_NEWLINE = 8'h0A;
    localparam byte_t CH_ESC     = 8'h1B;
    localparam byte_t CH_CTRL_A  = 8'h01;
    localparam byte_t CH_CTRL_Z  = 8'h1A;
    localparam byte_t CH_SPACE   = 8'h20;
    localparam byte_t CH_TILDE   = 8'h7E;
    localparam byte_t CH_DEL     = 8'h7F;
    localparam byte_t CH_LBRACK  = 8'h5B;
    localparam byte_t CH_ONE     = 8'h31;
    localparam byte_t CH_THREE   = 8'h33;
    localparam byte_t CH_FIVE    = 8'h35;
    localparam byte_t CH_SEMI    = 8'h3B;
    localparam byte_t CH_A       = 8'h41;
    localparam byte_t CH_D       = 8'h44;

endpackage

// ===== hw/rtl/terminal_key_sequence_decoder_unit.sv =====
// Terminal key sequence decoder: turns a terminal byte stream into dense key codes.

// The decoder takes one transaction per cycle on the slave side: a received byte in
// s_axis_tdata, or a gap (s_axis_tuser high) meaning no byte was waiting. Each
// transaction passes an input register, combinational decode logic against the parse
// phase register, and a result register; a new byte is taken every cycle while results
// drain. Plain bytes give keys directly; ESC opens a sequence (ESC gap = escape, ESC [
// A-D arrows, ESC [ 3 ~ delete, ESC [ 1 ; 5 A-D ctrl arrows). Bytes that open or
// continue a sequence, and most gaps, give no result; a byte that breaks a sequence
// gives key code none. The rate is set by the single phase register, which is updated
// once per transaction.
module terminal_key_sequence_decoder_unit
    import tksd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] no_byte
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] key_code, [14:8] ascii, [15] zero
);

    // Input register.
    logic   in_valid_reg;
    byte_t  in_byte_reg;
    logic   in_gap_reg;

    // Parse phase.
    phase_t phase_reg;
    phase_t phase_next;

    // Result register.
    logic   out_valid_reg;
    key_t   key_reg;
    ascii_t ascii_reg;

    // Decode results for the item in the input register.
    logic   emit;
    key_t   key_next;
    ascii_t ascii_next;
    logic   advance;

    // Decode one byte or gap against the current phase.
    always_comb
    begin
        emit       = 1'b0;
        key_next   = KC_NONE;
        ascii_next = '0;
        phase_next = phase_reg;
        if (in_gap_reg)
        begin
            if (phase_reg == PH_ESC)
            begin
                emit       = 1'b1;
                key_next   = KC_ESC;
                phase_next = PH_IDLE;
            end
        end
        else
        begin
            // Any emitted result returns to idle; overridden where a sequence continues.
            emit       = 1'b1;
            phase_next = PH_IDLE;
            case (phase_reg)
                PH_ESC:
                begin
                    if (in_byte_reg == CH_LBRACK)
                    begin
                        emit       = 1'b0;
                        phase_next = PH_CSI;
                    end
                end
                PH_CSI:
                begin
                    if (in_byte_reg >= CH_A && in_byte_reg <= CH_D)
                    begin
                        key_next = KC_ARROW0 + (in_byte_reg - CH_A);
                    end
                    else if (in_byte_reg == CH_THREE)
                    begin
                        emit       = 1'b0;
                        phase_next = PH_CSI3;
                    end
                    else if (in_byte_reg == CH_ONE)
                    begin
                        emit       = 1'b0;
                        phase_next = PH_CSI1;
                    end
                end
                PH_CSI3:
                begin
                    if (in_byte_reg == CH_TILDE)
                    begin
                        key_next = KC_DEL;
                    end
                end
                PH_CSI1:
                begin
                    if (in_byte_reg == CH_SEMI)
                    begin
                        emit       = 1'b0;
                        phase_next = PH_CSI1S;
                    end
                end
                PH_CSI1S:
                begin
                    if (in_byte_reg == CH_FIVE)
                    begin
                        emit       = 1'b0;
                        phase_next = PH_CSI1S5;
                    end
                end
                PH_CSI1S5:
                begin
                    if (in_byte_reg >= CH_A && in_byte_reg <= CH_D)
                    begin
                        key_next = KC_CARROW0 + (in_byte_reg - CH_A);
                    end
                end
                default:
                begin
                    // Idle: single-byte keys.
                    if (in_byte_reg == CH_NEWLINE)
                    begin
                        key_next = KC_ENTER;
                    end
                    else if (in_byte_reg >= CH_SPACE && in_byte_reg <= CH_TILDE)
                    begin
                        key_next   = KC_PRINT0 + (in_byte_reg - CH_SPACE);
                        ascii_next = in_byte_reg[6:0];
                    end
                    else if (in_byte_reg >= CH_CTRL_A && in_byte_reg <= CH_CTRL_Z)
                    begin
                        key_next = KC_CTRL_A + (in_byte_reg - CH_CTRL_A);
                    end
                    else if (in_byte_reg == CH_DEL)
                    begin
                        key_next = KC_BKSP;
                    end
                    else if (in_byte_reg == CH_ESC)
                    begin
                        emit       = 1'b0;
                        phase_next = PH_ESC;
                    end
                end
            endcase
        end
    end

    // The held item moves on unless its result would land on a stalled result register.
    assign advance       = in_valid_reg && (!emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register and parse phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_gap_reg  <= s_axis_tuser;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            key_reg   <= key_next;
            ascii_reg <= ascii_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, ascii_reg, key_reg};

    // Every result returns the parser to idle.
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> phase_reg == PH_IDLE)
        else $error("parse phase not idle after a result");

    // A gap while idle changes nothing.
    a_gap_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_gap_reg && phase_reg == PH_IDLE |-> !emit && phase_next == PH_IDLE)
        else $error("gap while idle produced activity");

    // Key codes stay in range and ascii only rides with printable keys.
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> key_reg <= KC_LAST &&
            (ascii_reg == '0 || key_reg == {1'b0, ascii_reg} - (CH_SPACE - KC_PRINT0)))
        else $error("result key code or ascii out of range");

    // A result never waits behind a new one that overwrites it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !(advance && emit))
        else $error("stalled result overwritten");

endmodule
